[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL top level; all use clk_i and an active-low rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/svsd_pkg.sv]
// Types and constants shared by the SVPWM sector and dwell pipeline.
package svsd_pkg;

  localparam int GAIN_BITS  = 16;
  localparam int GAIN_SHIFT = 30;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd1000;

  // Q14 weights: 1.5 and sqrt3/2; sqrt3 is taken as twice W_R.
  localparam logic signed [16:0] W_H = 17'sd24576;
  localparam logic signed [16:0] W_R = 17'sd14189;

  localparam logic [2:0] SECTOR_0 = 3'd0;
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;

  // Switch states, bit 2 phase a, bit 1 phase b, bit 0 phase c.
  localparam logic [2:0] V_100 = 3'b100;
  localparam logic [2:0] V_110 = 3'b110;
  localparam logic [2:0] V_010 = 3'b010;
  localparam logic [2:0] V_011 = 3'b011;
  localparam logic [2:0] V_001 = 3'b001;
  localparam logic [2:0] V_101 = 3'b101;

  typedef struct packed {
    logic mul_ld;
    logic out_ld;
  } stage_en_t;

  function automatic logic [2:0] first_vec(input logic [2:0] sector);
    logic [2:0] v;
    unique case (sector)
      SECTOR_0: v = V_100;
      SECTOR_1: v = V_110;
      SECTOR_2: v = V_010;
      SECTOR_3: v = V_011;
      SECTOR_4: v = V_001;
      SECTOR_5: v = V_101;
      default:  v = V_100;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] second_vec(input logic [2:0] sector);
    logic [2:0] v;
    unique case (sector)
      SECTOR_0: v = V_110;
      SECTOR_1: v = V_010;
      SECTOR_2: v = V_011;
      SECTOR_3: v = V_001;
      SECTOR_4: v = V_101;
      SECTOR_5: v = V_100;
      default:  v = V_110;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/svsd_scale.sv]
// Gain multiply, shift and saturation of one weighted sum into a dwell count.
module svsd_scale #(
  parameter int SUM_BITS  = 31,
  parameter int TIME_BITS = 16
) (
  input  logic                            clk_i,
  input  svsd_pkg::stage_en_t             ctrl_i,
  input  logic [svsd_pkg::GAIN_BITS-1:0]  gain_i,
  input  logic [SUM_BITS-1:0]             sum_i,
  output logic [TIME_BITS-1:0]            dwell_o
);

  localparam int GB   = svsd_pkg::GAIN_BITS;
  localparam int LW   = (SUM_BITS + 1) / 2;
  localparam int HW   = SUM_BITS - LW;
  localparam int PWID = GB + SUM_BITS;
  localparam int RW   = PWID - svsd_pkg::GAIN_SHIFT;
  localparam int CW   = (RW > TIME_BITS) ? RW : TIME_BITS;

  logic [GB+LW-1:0]    p_lo_q;
  logic [GB+HW-1:0]    p_hi_q;
  logic [PWID-1:0]     prod;
  logic [RW-1:0]       t_raw;
  logic [CW-1:0]       t_ext;
  logic [TIME_BITS-1:0] dwell_d, dwell_q;

  // The sum is split in two halves so each product stays a narrow multiplier.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_ld) begin
      p_lo_q <= (GB+LW)'(gain_i) * (GB+LW)'(sum_i[LW-1:0]);
      p_hi_q <= (GB+HW)'(gain_i) * (GB+HW)'(sum_i[SUM_BITS-1:LW]);
    end
  end

  assign prod  = {p_hi_q, {LW{1'b0}}} + PWID'(p_lo_q);
  assign t_raw = prod[PWID-1:svsd_pkg::GAIN_SHIFT];
  assign t_ext = CW'(t_raw);

  always_comb begin
    if (t_ext > CW'({TIME_BITS{1'b1}})) begin
      dwell_d = {TIME_BITS{1'b1}};
    end else begin
      dwell_d = t_ext[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_ld) begin
      dwell_q <= dwell_d;
    end
  end

  assign dwell_o = dwell_q;

endmodule

[hw/rtl/svsd_pipe.sv]
// Sector search and sector-weighted sums, stages one to three of the pipeline.
module svsd_pipe #(
  parameter int VOLTAGE_BITS = 16
) (
  input  logic                      clk_i,
  input  logic [2:0]                ld_i,
  input  logic [VOLTAGE_BITS-1:0]   alpha_i,
  input  logic [VOLTAGE_BITS-1:0]   beta_i,
  output logic [2:0]                sector_o,
  output logic [VOLTAGE_BITS+14:0]  sum1_o,
  output logic [VOLTAGE_BITS+14:0]  sum2_o
);

  localparam int VB = VOLTAGE_BITS;
  localparam int PW = VB + 16;
  localparam int SW = VB + 17;
  localparam int UW = VB + 15;

  logic [VB-1:0]          a_mag, b_mag;
  logic signed [VB-1:0]   a1_q, b1_q;
  logic [2*VB-1:0]        a2_q, b2_q;
  logic [2*VB+1:0]        a3, b2e;
  logic                   a_neg, a_pos, b_neg, b_pos, lt, le;
  logic [2:0]             sect2_d, sect2_q, sect3_q;
  logic signed [PW-1:0]   ha2_q, rb2_q;
  logic signed [SW-1:0]   ha, rb, qb, t1, t2;
  logic [UW-1:0]          s1_d, s2_d, s1_q, s2_q;

  // Stage 1: magnitudes squared for the exact boundary compare.
  assign a_mag = alpha_i[VB-1] ? (~alpha_i + VB'(1)) : alpha_i;
  assign b_mag = beta_i[VB-1]  ? (~beta_i + VB'(1))  : beta_i;

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      a1_q <= alpha_i;
      b1_q <= beta_i;
      a2_q <= (2*VB)'(a_mag) * (2*VB)'(a_mag);
      b2_q <= (2*VB)'(b_mag) * (2*VB)'(b_mag);
    end
  end

  // Stage 2: sector by signs and beta^2 against 3*alpha^2.
  assign a3    = {2'b00, a2_q} + {1'b0, a2_q, 1'b0};
  assign b2e   = {2'b00, b2_q};
  assign lt    = b2e < a3;
  assign le    = b2e <= a3;
  assign a_neg = a1_q[VB-1];
  assign a_pos = !a1_q[VB-1] && (a1_q != '0);
  assign b_neg = b1_q[VB-1];
  assign b_pos = !b1_q[VB-1] && (b1_q != '0);

  always_comb begin
    if (b_pos) begin
      if (a_pos && lt) begin
        sect2_d = svsd_pkg::SECTOR_0;
      end else if (a_neg && le) begin
        sect2_d = svsd_pkg::SECTOR_2;
      end else begin
        sect2_d = svsd_pkg::SECTOR_1;
      end
    end else if (!b_neg) begin
      // On the alpha axis only the sign of alpha matters.
      sect2_d = a_neg ? svsd_pkg::SECTOR_3 : svsd_pkg::SECTOR_0;
    end else if (a_neg && lt) begin
      sect2_d = svsd_pkg::SECTOR_3;
    end else if (a_pos && le) begin
      sect2_d = svsd_pkg::SECTOR_5;
    end else begin
      sect2_d = svsd_pkg::SECTOR_4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      sect2_q <= sect2_d;
      ha2_q   <= PW'(a1_q) * PW'(svsd_pkg::W_H);
      rb2_q   <= PW'(b1_q) * PW'(svsd_pkg::W_R);
    end
  end

  // Stage 3: pick the weighted sums of the sector and clamp negatives to zero.
  assign ha = SW'(ha2_q);
  assign rb = SW'(rb2_q);
  assign qb = rb <<< 1;

  always_comb begin
    case (sect2_q)
      svsd_pkg::SECTOR_0: begin t1 = ha - rb;  t2 = qb;       end
      svsd_pkg::SECTOR_1: begin t1 = ha + rb;  t2 = rb - ha;  end
      svsd_pkg::SECTOR_2: begin t1 = qb;       t2 = -ha - rb; end
      svsd_pkg::SECTOR_3: begin t1 = rb - ha;  t2 = -qb;      end
      svsd_pkg::SECTOR_4: begin t1 = -ha - rb; t2 = ha - rb;  end
      svsd_pkg::SECTOR_5: begin t1 = -qb;      t2 = ha + rb;  end
      default:            begin t1 = '0;       t2 = '0;       end
    endcase
  end

  assign s1_d = (t1[SW-1] || t1 == '0) ? '0 : t1[UW-1:0];
  assign s2_d = (t2[SW-1] || t2 == '0) ? '0 : t2[UW-1:0];

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      sect3_q <= sect2_q;
      s1_q    <= s1_d;
      s2_q    <= s2_d;
    end
  end

  assign sector_o = sect3_q;
  assign sum1_o   = s1_q;
  assign sum2_o   = s2_q;

endmodule

[hw/rtl/svpwm_sector_dwell.sv]
// Top level of the SVPWM sector and dwell-time pipeline.
//
//   Channel   Handshake                   Payload
//   input     in_valid_i / in_stall_o     alpha_voltage_i, beta_voltage_i
//   output    out_valid_o / out_stall_i   sector_o, first/second_vector_o,
//                                         first/second_dwell_o
//   config    cfg_we_i                    cfg_wdata_i (time gain)
//
// One beat per cycle is taken while in_stall_o is low.
// The five register stages are squares, sector compare, weighted sums,
// split gain products, and recombine with saturation.
// Reset clears the stage valid bits and loads the time gain with 1000.
// A stage moves when the stage after it is empty or moving, so bubbles close up
// and input beats are still taken while a result waits at the output.
module svpwm_sector_dwell #(
  parameter int VOLTAGE_BITS = 16,
  parameter int TIME_BITS    = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [svsd_pkg::GAIN_BITS-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [VOLTAGE_BITS-1:0]       alpha_voltage_i,
  input  logic signed [VOLTAGE_BITS-1:0]       beta_voltage_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [2:0]                           sector_o,
  output logic [2:0]                           first_vector_o,
  output logic [2:0]                           second_vector_o,
  output logic [TIME_BITS-1:0]                 first_dwell_o,
  output logic [TIME_BITS-1:0]                 second_dwell_o
);

  `include "assert_macros.svh"

  localparam int UW = VOLTAGE_BITS + 15;

  logic [svsd_pkg::GAIN_BITS-1:0] time_gain_q;
  logic [5:1]                     v_q;
  logic [5:1]                     en;
  logic [2:0]                     sect3, sect4_q, sect5_q;
  logic [UW-1:0]                  sum1, sum2;
  svsd_pkg::stage_en_t            scale_ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_gain_q <= svsd_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      time_gain_q <= cfg_wdata_i;
    end
  end

  assign en[5] = !v_q[5] || !out_stall_i;
  assign en[4] = !v_q[4] || en[5];
  assign en[3] = !v_q[3] || en[4];
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      if (en[4]) v_q[4] <= v_q[3];
      if (en[5]) v_q[5] <= v_q[4];
    end
  end

  svsd_pipe #(
    .VOLTAGE_BITS(VOLTAGE_BITS)
  ) u_pipe (
    .clk_i   (clk_i),
    .ld_i    ({en[3] && v_q[2], en[2] && v_q[1], en[1] && in_valid_i}),
    .alpha_i (alpha_voltage_i),
    .beta_i  (beta_voltage_i),
    .sector_o(sect3),
    .sum1_o  (sum1),
    .sum2_o  (sum2)
  );

  assign scale_ctrl.mul_ld = en[4] && v_q[3];
  assign scale_ctrl.out_ld = en[5] && v_q[4];

  always_ff @(posedge clk_i) begin
    if (scale_ctrl.mul_ld) begin
      sect4_q <= sect3;
    end
    if (scale_ctrl.out_ld) begin
      sect5_q <= sect4_q;
    end
  end

  svsd_scale #(
    .SUM_BITS (UW),
    .TIME_BITS(TIME_BITS)
  ) u_scale_first (
    .clk_i  (clk_i),
    .ctrl_i (scale_ctrl),
    .gain_i (time_gain_q),
    .sum_i  (sum1),
    .dwell_o(first_dwell_o)
  );

  svsd_scale #(
    .SUM_BITS (UW),
    .TIME_BITS(TIME_BITS)
  ) u_scale_second (
    .clk_i  (clk_i),
    .ctrl_i (scale_ctrl),
    .gain_i (time_gain_q),
    .sum_i  (sum2),
    .dwell_o(second_dwell_o)
  );

  assign in_stall_o      = !en[1];
  assign out_valid_o     = v_q[5];
  assign sector_o        = sect5_q;
  assign first_vector_o  = svsd_pkg::first_vec(sect5_q);
  assign second_vector_o = svsd_pkg::second_vec(sect5_q);

  // The input only stalls when every stage is full and the output is blocked.
  `ASSERT_SAME(a_stall_full, in_stall_o, (v_q == '1) && out_stall_i, "stall with a free stage")
  `ASSERT_SAME(a_sector_range, out_valid_o, sector_o <= svsd_pkg::SECTOR_5, "sector out of range")
  // A blocked stage must keep its beat.
  `ASSERT_NEXT(a_hold_mid, v_q[3] && !en[3], v_q[3], "beat lost in a blocked stage")
  // A stalled result beat stays on the output unchanged.
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(sector_o) && $stable(first_dwell_o) && $stable(second_dwell_o), "stalled result changed")

endmodule

[sim/tb.sv]
// Self-checking testbench for the SVPWM sector and dwell-time pipeline.
module tb;

  localparam int VBITS      = 16;
  localparam int TBITS      = 16;
  localparam int GBITS      = svsd_pkg::GAIN_BITS;
  localparam int LATENCY    = 5;
  localparam int PHASES     = 7;
  localparam int PHASE_BEATS = 190;
  localparam int HOLD_LEN   = 80;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [2:0]       sector;
    logic [2:0]       first_vec;
    logic [2:0]       second_vec;
    logic [TBITS-1:0] first_dwell;
    logic [TBITS-1:0] second_dwell;
  } dwell_result_t;

  // Predicts sector, vectors and dwell times, and checks results in order.
  class dwell_predictor;
    logic [GBITS-1:0]     gain;
    dwell_result_t        expected_dwells[$];
    int                   mismatches;

    function new();
      gain       = svsd_pkg::GAIN_RESET;
      mismatches = 0;
    endfunction

    function void set_gain(logic [GBITS-1:0] g);
      gain = g;
    endfunction

    function int pending();
      return expected_dwells.size();
    endfunction

    // Negative weighted sums give no on time; long ones saturate.
    function logic [TBITS-1:0] dwell_time(longint wsum);
      longint t;
      if (wsum <= 0) return '0;
      t = (longint'(gain) * wsum) >> svsd_pkg::GAIN_SHIFT;
      if (t > longint'({TBITS{1'b1}})) return {TBITS{1'b1}};
      return t[TBITS-1:0];
    endfunction

    function void take_reference(logic signed [VBITS-1:0] alpha,
                                 logic signed [VBITS-1:0] beta);
      longint        a, b, ma, mb, b2, a3, h, r, q, s1, s2;
      dwell_result_t res;
      a  = longint'(alpha);
      b  = longint'(beta);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      b2 = mb * mb;
      a3 = 3 * ma * ma;
      h  = longint'(svsd_pkg::W_H);
      r  = longint'(svsd_pkg::W_R);
      q  = 2 * r;
      // Exact comparison of beta^2 against 3*alpha^2; a boundary angle
      // belongs to the sector that starts there.
      if (b > 0) begin
        if (a > 0 && b2 < a3) res.sector = svsd_pkg::SECTOR_0;
        else if (a < 0 && b2 <= a3) res.sector = svsd_pkg::SECTOR_2;
        else res.sector = svsd_pkg::SECTOR_1;
      end else if (b == 0) begin
        res.sector = (a < 0) ? svsd_pkg::SECTOR_3 : svsd_pkg::SECTOR_0;
      end else begin
        if (a < 0 && b2 < a3) res.sector = svsd_pkg::SECTOR_3;
        else if (a > 0 && b2 <= a3) res.sector = svsd_pkg::SECTOR_5;
        else res.sector = svsd_pkg::SECTOR_4;
      end
      case (res.sector)
        svsd_pkg::SECTOR_0: begin
          res.first_vec = svsd_pkg::V_100; res.second_vec = svsd_pkg::V_110;
          s1 = h * a - r * b;    s2 = q * b;
        end
        svsd_pkg::SECTOR_1: begin
          res.first_vec = svsd_pkg::V_110; res.second_vec = svsd_pkg::V_010;
          s1 = h * a + r * b;    s2 = -h * a + r * b;
        end
        svsd_pkg::SECTOR_2: begin
          res.first_vec = svsd_pkg::V_010; res.second_vec = svsd_pkg::V_011;
          s1 = q * b;            s2 = -h * a - r * b;
        end
        svsd_pkg::SECTOR_3: begin
          res.first_vec = svsd_pkg::V_011; res.second_vec = svsd_pkg::V_001;
          s1 = -h * a + r * b;   s2 = -q * b;
        end
        svsd_pkg::SECTOR_4: begin
          res.first_vec = svsd_pkg::V_001; res.second_vec = svsd_pkg::V_101;
          s1 = -h * a - r * b;   s2 = h * a - r * b;
        end
        default: begin
          res.first_vec = svsd_pkg::V_101; res.second_vec = svsd_pkg::V_100;
          s1 = -q * b;           s2 = h * a + r * b;
        end
      endcase
      res.first_dwell  = dwell_time(s1);
      res.second_dwell = dwell_time(s2);
      expected_dwells.push_back(res);
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      mismatches++;
    endtask

    task match_result(dwell_result_t got);
      dwell_result_t want;
      if (expected_dwells.size() == 0) begin
        report("unexpected result beat", longint'(1), longint'(0));
        return;
      end
      want = expected_dwells.pop_front();
      if (got.sector !== want.sector)
        report("sector", longint'(got.sector), longint'(want.sector));
      if (got.first_vec !== want.first_vec)
        report("first_vector", longint'(got.first_vec), longint'(want.first_vec));
      if (got.second_vec !== want.second_vec)
        report("second_vector", longint'(got.second_vec), longint'(want.second_vec));
      if (got.first_dwell !== want.first_dwell)
        report("first_dwell", longint'(got.first_dwell), longint'(want.first_dwell));
      if (got.second_dwell !== want.second_dwell)
        report("second_dwell", longint'(got.second_dwell), longint'(want.second_dwell));
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [GBITS-1:0]        cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [VBITS-1:0] alpha_voltage_i = '0;
  logic signed [VBITS-1:0] beta_voltage_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [2:0]              sector_o;
  logic [2:0]              first_vector_o;
  logic [2:0]              second_vector_o;
  logic [TBITS-1:0]        first_dwell_o;
  logic [TBITS-1:0]        second_dwell_o;

  dwell_predictor dwell_model = new();
  int             send_idle_pct = 0;
  int             stall_pct = 0;
  int             hold_cycles = 0;
  int             cycle_count = 0;

  svpwm_sector_dwell #(
    .VOLTAGE_BITS(VBITS),
    .TIME_BITS   (TBITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .alpha_voltage_i(alpha_voltage_i),
    .beta_voltage_i (beta_voltage_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sector_o       (sector_o),
    .first_vector_o (first_vector_o),
    .second_vector_o(second_vector_o),
    .first_dwell_o  (first_dwell_o),
    .second_dwell_o (second_dwell_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver counts down a long hold-off on its own, else stalls at random.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i = 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i = ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      dwell_model.match_result({sector_o, first_vector_o, second_vector_o,
                                first_dwell_o, second_dwell_o});
  end

  task send_reference(int alpha, int beta);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    alpha_voltage_i = alpha[VBITS-1:0];
    beta_voltage_i  = beta[VBITS-1:0];
    do @(posedge clk_i); while (in_stall_o);
    dwell_model.take_reference(alpha_voltage_i, beta_voltage_i);
  endtask

  task write_gain(logic [GBITS-1:0] g);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = g;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    dwell_model.set_gain(g);
  endtask

  function int edge_voltage();
    case ($urandom_range(4))
      0:       return 32767;
      1:       return -32768;
      2:       return 0;
      3:       return 1;
      default: return -1;
    endcase
  endfunction

  // Mix of full-range values, edges, axes, tiny values and points hugging the
  // 60-degree sector lines.
  task send_random_reference();
    int a, b, mag;
    case ($urandom_range(7))
      0: begin a = edge_voltage(); b = edge_voltage(); end
      1: begin a = $urandom_range(16) - 8; b = $urandom_range(16) - 8; end
      2: begin
        mag = $urandom_range(18918);
        a   = mag;
        b   = (mag * 1732) / 1000 + $urandom_range(4) - 2;
        if ($urandom_range(1)) a = -a;
        if ($urandom_range(1)) b = -b;
      end
      3: begin
        a = $signed($urandom()) >>> 16;
        b = 0;
        if ($urandom_range(1)) begin b = a; a = 0; end
      end
      default: begin
        a = $signed($urandom()) >>> 16;
        b = $signed($urandom()) >>> 16;
      end
    endcase
    send_reference(a, b);
  endtask

  task send_directed();
    send_reference(0, 0);
    send_reference(32767, 0);
    send_reference(-32768, 0);
    send_reference(1, 0);
    send_reference(-1, 0);
    send_reference(0, 32767);
    send_reference(0, -32768);
    send_reference(32767, 32767);
    send_reference(-32768, -32768);
    send_reference(32767, -32768);
    send_reference(-32768, 32767);
    send_reference(-1, 1);
    send_reference(1, -1);
    send_reference(1000, 1732);
    send_reference(1000, 1733);
    send_reference(-1000, 1732);
    send_reference(-1000, 1733);
    send_reference(-1000, -1732);
    send_reference(-1000, -1733);
    send_reference(1000, -1732);
    send_reference(1000, -1733);
  endtask

  task wait_drained();
    while (dwell_model.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 3) @(posedge clk_i);
  endtask

  initial begin
    int p, n;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (p = 0; p < PHASES; p++) begin
      @(posedge clk_i);
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  write_gain('0); end
        2: begin send_idle_pct = 0;  stall_pct = 75; write_gain({GBITS{1'b1}}); end
        3: begin send_idle_pct = 12; stall_pct = 12; write_gain(GBITS'(1)); end
        4: begin
          send_idle_pct = 0;  stall_pct = 0;
          write_gain(GBITS'($urandom_range(65535)));
        end
        5: begin send_idle_pct = 12; stall_pct = 12; write_gain({GBITS{1'b1}}); end
        default: begin
          send_idle_pct = 75; stall_pct = 75;
          write_gain(GBITS'($urandom_range(65535)));
        end
      endcase
      if (p == 0) send_directed();
      // Hold the output off while beats keep coming so the pipeline fills.
      if (p == 4) begin
        @(posedge clk_i);
        hold_cycles = HOLD_LEN;
      end
      for (n = 0; n < PHASE_BEATS; n++) send_random_reference();
      @(negedge clk_i);
      in_valid_i = 1'b0;
      wait_drained();
    end
    if (dwell_model.mismatches == 0 && dwell_model.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/svsd_pkg.sv
hw/rtl/svsd_scale.sv
hw/rtl/svsd_pipe.sv
hw/rtl/svpwm_sector_dwell.sv
sim/tb.sv
